>>> design/gcc_pkg.sv
// Shared types and constants for the greedy coin change unit.
package gcc_pkg;

    localparam int MAX_COINS = 8;
    localparam int IDX_W     = 3;
    localparam int AMT_W     = 31;
    localparam int COIN_W    = 16;
    localparam int DIV_W     = 32;
    localparam int STEPS     = 8;
    localparam int BITS_PER_STEP = DIV_W / STEPS;
    localparam int PADDR_W   = 5;

    typedef logic [MAX_COINS-1:0][COIN_W-1:0] t_coins;
    typedef logic [MAX_COINS-1:0][AMT_W-1:0]  t_counts;

    // word travelling down the chain of cells
    typedef struct packed {
        logic              zero;
        logic [AMT_W-1:0]  rem;
        logic [AMT_W-1:0]  total;
        t_counts           counts;
    } t_token;

endpackage

>>> design/greedy_coin_change_unit.sv
// Greedy coin change unit: top level.
// Usage: program denominations through the APB port (register i at byte 4*i,
// low 16 bits; zero marks an unused slot), only while the unit is idle.
// Present an amount on i_amount with start; it is taken when start is high
// and busy is low. Results appear one word per cycle with o_valid high for
// that single cycle; the receiver cannot stall and every word must be taken.
// An exact payout gives NUM_COINS words, largest denomination first, the last
// one with o_last and o_total_coins. A zero amount, or an amount left with a
// remainder, gives one word with o_last (o_status 1 when not possible).
// Each amount passes through the NUM_COINS cells in turn, then is registered in
// the emit stage before the first result word. A new amount is taken only when
// the first cell, running a radix-16 division on its 31-bit remainder, is not busy.
// Reset clears all denominations to zero and empties the pipeline.
module greedy_coin_change_unit #(
    parameter int NUM_COINS = gcc_pkg::MAX_COINS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [gcc_pkg::AMT_W-1:0]   i_amount,
    output logic                        o_valid,
    output logic [gcc_pkg::COIN_W-1:0]  o_denomination,
    output logic [gcc_pkg::AMT_W-1:0]   o_coin_count,
    output logic [gcc_pkg::AMT_W-1:0]   o_total_coins,
    output logic                        o_status,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gcc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    gcc_pkg::t_coins            r_coin;
    gcc_pkg::t_coins            sorted;
    logic [gcc_pkg::IDX_W-1:0]  reg_idx;
    logic                       wr_en;
    logic                       valid_c [NUM_COINS+1];
    gcc_pkg::t_token            tok_c   [NUM_COINS+1];
    logic                       busy_c  [NUM_COINS];

    assign pready  = 1'b1;
    assign reg_idx = paddr[gcc_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign prdata  = {16'h0000, r_coin[reg_idx]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coin <= '0;
        end else if (wr_en) begin
            r_coin[reg_idx] <= pwdata[gcc_pkg::COIN_W-1:0];
        end
    end

    gcc_sort #(.NUM_COINS(NUM_COINS)) u_sort (
        .i_clk    (i_clk),
        .i_coins  (r_coin),
        .o_sorted (sorted)
    );

    always_comb begin
        valid_c[0]        = start && !busy;
        tok_c[0].zero     = (i_amount == '0);
        tok_c[0].rem      = i_amount;
        tok_c[0].total    = '0;
        tok_c[0].counts   = '0;
    end

    assign busy = busy_c[0];

    for (genvar k = 0; k < NUM_COINS; k++) begin : g_cell
        gcc_cell #(.IDX(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid_c[k]),
            .i_tok   (tok_c[k]),
            .i_coin  (sorted[k]),
            .o_valid (valid_c[k+1]),
            .o_tok   (tok_c[k+1]),
            .o_busy  (busy_c[k])
        );
    end

    gcc_emit #(.NUM_COINS(NUM_COINS)) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (valid_c[NUM_COINS]),
        .i_tok          (tok_c[NUM_COINS]),
        .i_sorted       (sorted),
        .o_valid        (o_valid),
        .o_denomination (o_denomination),
        .o_coin_count   (o_coin_count),
        .o_total_coins  (o_total_coins),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule

>>> design/gcc_sort.sv
// Ranks the configured denominations and registers them in descending order.
module gcc_sort #(
    parameter int NUM_COINS = gcc_pkg::MAX_COINS
) (
    input  logic           i_clk,
    input  gcc_pkg::t_coins i_coins,
    output gcc_pkg::t_coins o_sorted
);

    gcc_pkg::t_coins r_sorted;
    gcc_pkg::t_coins n_sorted;
    logic [gcc_pkg::IDX_W-1:0] rank [gcc_pkg::MAX_COINS];

    // stable descending order: earlier slot wins a tie
    always_comb begin
        for (int i = 0; i < gcc_pkg::MAX_COINS; i++) begin
            rank[i] = '0;
            for (int j = 0; j < gcc_pkg::MAX_COINS; j++) begin
                if (i < NUM_COINS && j < NUM_COINS && j != i) begin
                    if (i_coins[j] > i_coins[i] || (i_coins[j] == i_coins[i] && j < i)) begin
                        rank[i] = rank[i] + gcc_pkg::IDX_W'(1);
                    end
                end
            end
        end
        for (int p = 0; p < gcc_pkg::MAX_COINS; p++) begin
            n_sorted[p] = '0;
            for (int i = 0; i < NUM_COINS; i++) begin
                if (rank[i] == gcc_pkg::IDX_W'(p)) begin
                    n_sorted[p] = n_sorted[p] | i_coins[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sorted <= n_sorted;
    end

    assign o_sorted = r_sorted;

endmodule

>>> design/gcc_cell.sv
// One cell of the chain: divides the remainder by one denomination, 4 bits a cycle.
module gcc_cell #(
    parameter int IDX = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  gcc_pkg::t_token            i_tok,
    input  logic [gcc_pkg::COIN_W-1:0] i_coin,
    output logic                       o_valid,
    output gcc_pkg::t_token            o_tok,
    output logic                       o_busy
);

    localparam logic [gcc_pkg::IDX_W-1:0] LAST_STEP = gcc_pkg::IDX_W'(gcc_pkg::STEPS - 1);

    logic                       r_act, n_act;
    logic [gcc_pkg::IDX_W-1:0]  r_step, n_step;
    gcc_pkg::t_token            r_tok, n_tok;
    logic [gcc_pkg::DIV_W-1:0]  r_d, n_d, dv;
    logic [gcc_pkg::COIN_W-1:0] r_p, n_p, pv;
    logic [gcc_pkg::DIV_W-1:0]  r_q, n_q, qv;
    logic [gcc_pkg::COIN_W:0]   p17;
    logic                       done;

    assign done   = r_act && (r_step == LAST_STEP);
    assign o_busy = r_act && (r_step != LAST_STEP);
    assign o_valid = done;

    // restoring division, a few quotient bits per cycle
    always_comb begin
        pv = r_p;
        dv = r_d;
        qv = r_q;
        p17 = '0;
        for (int b = 0; b < gcc_pkg::BITS_PER_STEP; b++) begin
            p17 = {pv, dv[gcc_pkg::DIV_W-1]};
            dv  = {dv[gcc_pkg::DIV_W-2:0], 1'b0};
            if (i_coin != '0 && p17 >= {1'b0, i_coin}) begin
                p17 = p17 - {1'b0, i_coin};
                qv  = {qv[gcc_pkg::DIV_W-2:0], 1'b1};
            end else begin
                qv  = {qv[gcc_pkg::DIV_W-2:0], 1'b0};
            end
            pv = p17[gcc_pkg::COIN_W-1:0];
        end
    end

    always_comb begin
        o_tok = r_tok;
        o_tok.counts[IDX] = qv[gcc_pkg::AMT_W-1:0];
        o_tok.total = r_tok.total + qv[gcc_pkg::AMT_W-1:0];
        if (i_coin != '0) begin
            o_tok.rem = {{(gcc_pkg::AMT_W-gcc_pkg::COIN_W){1'b0}}, pv};
        end
    end

    always_comb begin
        n_act  = r_act;
        n_step = r_step;
        n_tok  = r_tok;
        n_d    = r_d;
        n_p    = r_p;
        n_q    = r_q;
        if (i_valid && !o_busy) begin
            n_act  = 1'b1;
            n_step = '0;
            n_tok  = i_tok;
            n_d    = {1'b0, i_tok.rem};
            n_p    = '0;
            n_q    = '0;
        end else if (r_act) begin
            n_d = dv;
            n_p = pv;
            n_q = qv;
            if (done) begin
                n_act = 1'b0;
            end else begin
                n_step = r_step + gcc_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_step <= '0;
        end else begin
            r_act  <= n_act;
            r_step <= n_step;
        end
        r_tok <= n_tok;
        r_d   <= n_d;
        r_p   <= n_p;
        r_q   <= n_q;
    end

endmodule

>>> design/gcc_emit.sv
// Serializes one finished word into its result words, one per cycle.
module gcc_emit #(
    parameter int NUM_COINS = gcc_pkg::MAX_COINS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  gcc_pkg::t_token            i_tok,
    input  gcc_pkg::t_coins            i_sorted,
    output logic                       o_valid,
    output logic [gcc_pkg::COIN_W-1:0] o_denomination,
    output logic [gcc_pkg::AMT_W-1:0]  o_coin_count,
    output logic [gcc_pkg::AMT_W-1:0]  o_total_coins,
    output logic                       o_status,
    output logic                       o_last
);

    localparam logic [gcc_pkg::IDX_W-1:0] LAST_IDX = gcc_pkg::IDX_W'(NUM_COINS - 1);

    logic                      r_act, n_act;
    logic [gcc_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                      r_single, n_single;
    logic                      r_status, n_status;
    gcc_pkg::t_token           r_tok, n_tok;
    logic                      is_last;

    assign is_last = r_single || (r_idx == LAST_IDX);

    always_comb begin
        n_act    = r_act;
        n_idx    = r_idx;
        n_single = r_single;
        n_status = r_status;
        n_tok    = r_tok;
        if (i_valid) begin
            n_act    = 1'b1;
            n_idx    = '0;
            n_single = i_tok.zero || (i_tok.rem != '0);
            n_status = !i_tok.zero && (i_tok.rem != '0);
            n_tok    = i_tok;
        end else if (r_act) begin
            if (is_last) begin
                n_act = 1'b0;
            end else begin
                n_idx = r_idx + gcc_pkg::IDX_W'(1);
            end
        end
    end

    always_comb begin
        o_valid        = r_act;
        o_status       = r_status;
        o_last         = is_last;
        o_denomination = r_single ? '0 : i_sorted[r_idx];
        o_coin_count   = r_single ? '0 : r_tok.counts[r_idx];
        o_total_coins  = (is_last && !r_single) ? r_tok.total : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_idx <= '0;
        end else begin
            r_act <= n_act;
            r_idx <= n_idx;
        end
        r_single <= n_single;
        r_status <= n_status;
        r_tok    <= n_tok;
    end

endmodule

>>> design/gcc_checker.sv
// Port-level checks for the greedy coin change unit, bound to the top level.
module gcc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic [gcc_pkg::COIN_W-1:0] o_denomination,
    input logic [gcc_pkg::AMT_W-1:0]  o_coin_count,
    input logic [gcc_pkg::AMT_W-1:0]  o_total_coins,
    input logic                       o_status,
    input logic                       o_last
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("unit not idle after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepting a word");

    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_last && o_coin_count == '0 && o_denomination == '0)
        else $error("not-possible result malformed");

    a_total_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_total_coins == '0)
        else $error("total shown before last word");

endmodule

bind greedy_coin_change_unit gcc_checker u_gcc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_denomination (o_denomination),
    .o_coin_count   (o_coin_count),
    .o_total_coins  (o_total_coins),
    .o_status       (o_status),
    .o_last         (o_last)
);

>>> test/tb.sv
// Testbench for the greedy coin change unit: directed and random amounts checked per word.
`timescale 1ns / 1ps

module tb;

    localparam int LAT = 8 * gcc_pkg::MAX_COINS + 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [gcc_pkg::COIN_W-1:0] denom;
        logic [gcc_pkg::AMT_W-1:0]  cnt;
        logic [gcc_pkg::AMT_W-1:0]  total;
        logic                       status;
        logic                       last;
    } t_payout;

    typedef struct {
        logic [gcc_pkg::AMT_W-1:0]  amount;
        logic                       known;
        logic                       status;
        logic [gcc_pkg::AMT_W-1:0]  total;
    } t_row;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic start = 0;
    logic busy;
    logic [gcc_pkg::AMT_W-1:0] i_amount = '0;
    logic o_valid;
    logic [gcc_pkg::COIN_W-1:0] o_denomination;
    logic [gcc_pkg::AMT_W-1:0] o_coin_count, o_total_coins;
    logic o_status, o_last;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [gcc_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    greedy_coin_change_unit u_top (.*);

    always #6 i_clk = ~i_clk;

    logic [gcc_pkg::COIN_W-1:0] denoms [gcc_pkg::MAX_COINS];
    t_payout payout_q [$];
    int errors = 0;
    int amounts_sent = 0;
    int words_seen = 0;
    int cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // greedy payout predicted from the shadow denominations
    function automatic void predict_payout(logic [gcc_pkg::AMT_W-1:0] amount);
        logic [gcc_pkg::COIN_W-1:0] order [gcc_pkg::MAX_COINS];
        logic [gcc_pkg::AMT_W-1:0] taken [gcc_pkg::MAX_COINS];
        logic [gcc_pkg::COIN_W-1:0] v;
        logic [gcc_pkg::AMT_W-1:0] rest;
        logic [gcc_pkg::AMT_W-1:0] sum;
        t_payout p;
        int j;
        rest = amount;
        sum = '0;
        if (amount == 0) begin
            p = '{'0, '0, '0, 1'b0, 1'b1};
            payout_q.push_back(p);
            return;
        end
        for (int i = 0; i < gcc_pkg::MAX_COINS; i++) order[i] = denoms[i];
        for (int i = 1; i < gcc_pkg::MAX_COINS; i++) begin
            v = order[i];
            j = i - 1;
            while (j >= 0 && order[j] < v) begin
                order[j + 1] = order[j];
                j--;
            end
            order[j + 1] = v;
        end
        for (int i = 0; i < gcc_pkg::MAX_COINS; i++) begin
            taken[i] = '0;
            if (order[i] != 0 && rest >= order[i]) begin
                taken[i] = rest / order[i];
                sum += taken[i];
                rest = rest % order[i];
            end
        end
        if (rest != 0) begin
            p = '{'0, '0, '0, 1'b1, 1'b1};
            payout_q.push_back(p);
            return;
        end
        for (int i = 0; i < gcc_pkg::MAX_COINS; i++) begin
            p.denom = order[i];
            p.cnt = taken[i];
            p.last = (i == gcc_pkg::MAX_COINS - 1);
            p.total = p.last ? sum : '0;
            p.status = 1'b0;
            payout_q.push_back(p);
        end
    endfunction

    always @(posedge i_clk) begin
        t_payout e;
        if (i_rst_n && o_valid) begin
            words_seen <= words_seen + 1;
            if (payout_q.size() == 0) begin
                $display("%0t: unexpected word denom=%0d cnt=%0d", $time,
                         o_denomination, o_coin_count);
                errors <= errors + 1;
            end else begin
                e = payout_q.pop_front();
                if (o_denomination !== e.denom || o_coin_count !== e.cnt ||
                    o_total_coins !== e.total || o_status !== e.status ||
                    o_last !== e.last) begin
                    $display("%0t: expected d=%0d c=%0d t=%0d s=%0b l=%0b",
                             $time, e.denom, e.cnt, e.total, e.status, e.last);
                    $display("%0t: actual   d=%0d c=%0d t=%0d s=%0b l=%0b",
                             $time, o_denomination, o_coin_count, o_total_coins,
                             o_status, o_last);
                    errors <= errors + 1;
                end
            end
        end
    end

    task automatic write_denom(int slot, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= gcc_pkg::PADDR_W'(4 * slot); pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        denoms[slot] = value[gcc_pkg::COIN_W-1:0];
    endtask

    task automatic load_denoms(logic [gcc_pkg::COIN_W-1:0] a0, a1, a2, a3, a4, a5, a6, a7);
        logic [gcc_pkg::COIN_W-1:0] set [gcc_pkg::MAX_COINS];
        set = '{a0, a1, a2, a3, a4, a5, a6, a7};
        for (int i = 0; i < gcc_pkg::MAX_COINS; i++)
            write_denom(i, {16'($urandom), set[i]});
    endtask

    task automatic drain_payouts();
        start <= 0;
        while (payout_q.size() != 0) @(posedge i_clk);
        repeat (LAT) @(posedge i_clk);
    endtask

    // start stays high between back-to-back words; drain_payouts drops it
    task automatic send_amount(logic [gcc_pkg::AMT_W-1:0] amount, logic known = 1'b0,
                               logic status = 1'b0,
                               logic [gcc_pkg::AMT_W-1:0] total = '0);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1;
        i_amount <= amount;
        do @(posedge i_clk); while (busy);
        if (known) payout_q.push_back(t_payout'{'0, '0, total, status, 1'b1});
        else predict_payout(amount);
        amounts_sent++;
    endtask

    function automatic logic [gcc_pkg::AMT_W-1:0] rand_amount();
        case ($urandom_range(0, 3))
            0: return gcc_pkg::AMT_W'($urandom_range(0, 300));
            1: return gcc_pkg::AMT_W'($urandom_range(0, 70000));
            default: return gcc_pkg::AMT_W'($urandom);
        endcase
    endfunction

    // rows with a known single-word answer carry it; the rest use the predictor
    t_row rows [] = '{
        '{31'd0, 1'b1, 1'b0, 31'd0},
        '{31'd1, 1'b1, 1'b1, 31'd0},
        '{31'h7FFFFFFF, 1'b1, 1'b1, 31'd0},
        '{31'd1, 1'b0, 1'b0, 31'd0},
        '{31'd0, 1'b1, 1'b0, 31'd0},
        '{31'd3, 1'b0, 1'b0, 31'd0},
        '{31'd99, 1'b0, 1'b0, 31'd0},
        '{31'd12345, 1'b0, 1'b0, 31'd0},
        '{31'h7FFFFFFF, 1'b0, 1'b0, 31'd0},
        '{31'h55555555, 1'b0, 1'b0, 31'd0},
        '{31'h2AAAAAAA, 1'b0, 1'b0, 31'd0}
    };

    initial begin
        for (int i = 0; i < gcc_pkg::MAX_COINS; i++) denoms[i] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // reset: all slots unused, so only zero is payable
        for (int r = 0; r < 3; r++)
            send_amount(rows[r].amount, rows[r].known, rows[r].status, rows[r].total);
        drain_payouts();

        // unused slots and duplicates, with 1 present so everything is payable
        load_denoms(16'd0, 16'd5, 16'd1, 16'd5, 16'd0, 16'd25, 16'hFFFF, 16'd10);
        for (int r = 3; r < rows.size(); r++)
            send_amount(rows[r].amount, rows[r].known, rows[r].status, rows[r].total);
        drain_payouts();

        // no unit coin: many amounts not possible
        load_denoms(16'd7, 16'd3, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        for (int k = 0; k < 6; k++) send_amount(gcc_pkg::AMT_W'($urandom_range(1, 40)));
        drain_payouts();

        // random sets, extremes among them
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_denoms('1, '1, '1, '1, '1, '1, '1, 16'd1);
                1: load_denoms(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
                default: for (int i = 0; i < gcc_pkg::MAX_COINS; i++)
                    write_denom(i, ($urandom_range(0, 4) == 0) ? 32'd0 :
                                   ($urandom_range(0, 1) ? $urandom_range(1, 100)
                                                          : $urandom));
            endcase
            for (int k = 0; k < 28; k++) begin
                if (phase >= 2 && k == 0 && $urandom_range(0, 1))
                    write_denom($urandom_range(0, 3), 32'd1);
                send_amount(rand_amount());
            end
            drain_payouts();
        end
        drain_payouts();

        $display("%0d amounts sent, %0d words checked over several denomination sets",
                 amounts_sent, words_seen);
        if (errors == 0 && payout_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

>>> sim.f
design/gcc_pkg.sv
design/gcc_sort.sv
design/gcc_cell.sv
design/gcc_emit.sv
design/greedy_coin_change_unit.sv
design/gcc_checker.sv
test/tb.sv
